>>> rtl/dsc_pkg.sv
// Package: shared types and constants for the double sortedness checker.
`default_nettype none
package dsc_pkg;
  localparam int unsigned RUN_W = 17;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CLS_NUMBER  = 2'd0,
    CLS_MISSING = 2'd1,
    CLS_NAN     = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    VERDICT_SORTED   = 2'd0,
    VERDICT_REVERSED = 2'd1,
    VERDICT_UNSORTED = 2'd2
  } verdict_t;

  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING_LAST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAN_APART    = 2'd2;

  // Comparison result of current element against previous.
  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2
  } ord_t;

  typedef struct packed {
    logic descending;
    logic missing_last;
    logic nan_apart;
  } cfg_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic             run_closed;
    logic [RUN_W-1:0] run_length;
    logic             done_res;
    logic [1:0]       verdict;
  } out_item_t;
endpackage
`default_nettype wire

>>> rtl/dsc_in_if.sv
// Interface: input element channel.
`default_nettype none
interface dsc_in_if;
  logic              valid;
  logic              ready;
  dsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/dsc_out_if.sv
// Interface: result channel.
`default_nettype none
interface dsc_out_if;
  logic               valid;
  logic               ready;
  dsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/dsc_compare.sv
// Module: classifies a double and orders it against the previous element.
`default_nettype none
module dsc_compare (
  input  wire logic [63:0]   x_bits,
  input  wire logic [63:0]   y_bits,
  input  wire dsc_pkg::cls_t y_cls,
  input  wire dsc_pkg::cfg_t cfg,
  output dsc_pkg::cls_t      x_cls,
  output dsc_pkg::ord_t      ord
);
  logic x_nan;
  logic x_zero, y_zero;
  logic mag_lt, mag_eq;
  logic num_lt, num_gt;
  dsc_pkg::ord_t raw;

  assign x_nan  = (x_bits[62:52] == 11'h7FF) && (x_bits[51:0] != 52'd0);
  assign x_zero = (x_bits[62:0] == 63'd0);
  assign y_zero = (y_bits[62:0] == 63'd0);
  assign mag_lt = x_bits[62:0] < y_bits[62:0];
  assign mag_eq = x_bits[62:0] == y_bits[62:0];

  always_comb begin
    if (!x_nan) x_cls = dsc_pkg::CLS_NUMBER;
    else if (x_bits[31:0] == 32'd1954) x_cls = dsc_pkg::CLS_MISSING;
    else x_cls = dsc_pkg::CLS_NAN;
  end

  // Sign-magnitude compare; both zeros tie.
  always_comb begin
    num_lt = 1'b0;
    num_gt = 1'b0;
    if (!(x_zero && y_zero)) begin
      unique case ({x_bits[63], y_bits[63]})
        2'b00: begin num_lt = mag_lt; num_gt = !mag_lt && !mag_eq; end
        2'b11: begin num_gt = mag_lt; num_lt = !mag_lt && !mag_eq; end
        2'b10: num_lt = 1'b1;
        2'b01: num_gt = 1'b1;
        default: ;
      endcase
    end
  end

  // Non-number ordering: missing_last places NA/NaN after numbers.
  always_comb begin
    logic na_hi;
    na_hi = cfg.missing_last;
    raw = dsc_pkg::ORD_EQ;
    if (x_cls == dsc_pkg::CLS_NUMBER) begin
      if (y_cls == dsc_pkg::CLS_NUMBER) begin
        if (num_lt) raw = cfg.descending ? dsc_pkg::ORD_GT : dsc_pkg::ORD_LT;
        else if (num_gt) raw = cfg.descending ? dsc_pkg::ORD_LT : dsc_pkg::ORD_GT;
      end else begin
        raw = na_hi ? dsc_pkg::ORD_LT : dsc_pkg::ORD_GT;
      end
    end else if (y_cls == dsc_pkg::CLS_NUMBER) begin
      raw = na_hi ? dsc_pkg::ORD_GT : dsc_pkg::ORD_LT;
    end else if (x_cls != y_cls && cfg.nan_apart) begin
      // Missing sits beyond NaN on the same side; NaN lies next to the numbers.
      if (x_cls == dsc_pkg::CLS_MISSING) raw = na_hi ? dsc_pkg::ORD_GT : dsc_pkg::ORD_LT;
      else raw = na_hi ? dsc_pkg::ORD_LT : dsc_pkg::ORD_GT;
    end
  end

  assign ord = raw;
endmodule
`default_nettype wire

>>> rtl/double_sortedness_checker.sv
// Top level: streaming sortedness checker for IEEE doubles.
// One element is taken per cycle, back to back, with a ready consumer.
// Each transfer on in_ yields exactly one result on out_: the element is
// compared with the previous one in a single combinational step (classify,
// sign-magnitude compare, ordering rules) and the result lands in the output
// register. A new transfer is taken whenever that register is empty or being
// drained. Tie runs are reported as they close while the stream is still
// sorted; on the element marked last the verdict (0 sorted, 1 reversed,
// 2 unsorted) and, if still sorted, a run length are given and the stream
// state returns to reset. Runs saturate at the smaller of MAX_LENGTH and
// 2**RUN_W-1. Configuration writes take effect on the next comparison.
`default_nettype none
module double_sortedness_checker #(
  parameter longint unsigned MAX_LENGTH = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  dsc_in_if.sink                              in_ch,
  dsc_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic                           cfg_data
);
  localparam longint unsigned FIELD_MAX = (64'd1 << dsc_pkg::RUN_W) - 64'd1;
  localparam logic [dsc_pkg::RUN_W-1:0] RUN_CAP =
    dsc_pkg::RUN_W'((MAX_LENGTH > FIELD_MAX) ? FIELD_MAX : MAX_LENGTH);

  dsc_pkg::cfg_t   cfg_r;
  logic [63:0]     prev_val_r;
  dsc_pkg::cls_t   prev_cls_r;
  logic            at_first_r, rev_r, ord_r;
  logic [dsc_pkg::RUN_W-1:0] run_r;
  logic            out_valid_r;
  dsc_pkg::out_item_t out_r;

  dsc_pkg::cls_t   x_cls;
  dsc_pkg::ord_t   ord;
  logic            take;

  logic            rev_nxt, ord_nxt, closed;
  logic [dsc_pkg::RUN_W-1:0] run_nxt;
  dsc_pkg::out_item_t out_nxt;

  dsc_compare u_cmp (
    .x_bits (in_ch.data.value_bits),
    .y_bits (prev_val_r),
    .y_cls  (prev_cls_r),
    .cfg    (cfg_r),
    .x_cls  (x_cls),
    .ord    (ord)
  );

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign take         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    rev_nxt = rev_r;
    ord_nxt = ord_r;
    run_nxt = run_r;
    closed  = 1'b0;
    if (!at_first_r) begin
      if (ord != dsc_pkg::ORD_LT) rev_nxt = 1'b0;
      if (ord == dsc_pkg::ORD_LT) ord_nxt = 1'b0;
      if (ord_nxt) begin
        if (ord == dsc_pkg::ORD_EQ) begin
          if (run_r < RUN_CAP) run_nxt = run_r + dsc_pkg::RUN_W'(1);
        end else begin
          closed  = 1'b1;
          run_nxt = dsc_pkg::RUN_W'(1);
        end
      end
    end
    out_nxt.run_closed = closed;
    out_nxt.done_res   = in_ch.data.last;
    if (closed) out_nxt.run_length = run_r;
    else if (in_ch.data.last && ord_nxt) out_nxt.run_length = run_nxt;
    else out_nxt.run_length = '0;
    if (!in_ch.data.last) out_nxt.verdict = dsc_pkg::VERDICT_SORTED;
    else if (ord_nxt) out_nxt.verdict = dsc_pkg::VERDICT_SORTED;
    else if (rev_nxt) out_nxt.verdict = dsc_pkg::VERDICT_REVERSED;
    else out_nxt.verdict = dsc_pkg::VERDICT_UNSORTED;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{descending: 1'b0, missing_last: 1'b1, nan_apart: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsc_pkg::REG_DESCENDING:   cfg_r.descending   <= cfg_data;
        dsc_pkg::REG_MISSING_LAST: cfg_r.missing_last <= cfg_data;
        dsc_pkg::REG_NAN_APART:    cfg_r.nan_apart    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stream state; returns to reset after the last element.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_val_r <= '0;
      prev_cls_r <= dsc_pkg::CLS_NUMBER;
      at_first_r <= 1'b1;
      rev_r      <= 1'b1;
      ord_r      <= 1'b1;
      run_r      <= dsc_pkg::RUN_W'(1);
    end else if (take) begin
      if (in_ch.data.last) begin
        prev_val_r <= '0;
        prev_cls_r <= dsc_pkg::CLS_NUMBER;
        at_first_r <= 1'b1;
        rev_r      <= 1'b1;
        ord_r      <= 1'b1;
        run_r      <= dsc_pkg::RUN_W'(1);
      end else begin
        prev_val_r <= in_ch.data.value_bits;
        prev_cls_r <= x_cls;
        at_first_r <= 1'b0;
        rev_r      <= rev_nxt;
        ord_r      <= ord_nxt;
        run_r      <= run_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (take) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) out_r <= out_nxt;
  end
endmodule
`default_nettype wire
